// ===== rtl/tdp_pkg.sv =====
`timescale 1ns / 1ps

package tdp_pkg;

  // Candidate width, fixed by the candidate field.
  localparam int NW   = 32;
  // Divisor/remainder width: trial divisors stay below 2^(NW/2+1).
  localparam int DW   = NW / 2 + 2;
  // Width of the divisor-squared register (holds values past 2^NW).
  localparam int SW   = NW + 2;
  // Bit counter of the serial remainder unit.
  localparam int CNTW = $clog2(NW);

  typedef struct packed {
    logic done;   // one-cycle pulse: remainder is ready
    logic zero;   // remainder is zero (valid with done)
  } rem_stat_t;

endpackage

// ===== rtl/tdp_rem.sv =====
`timescale 1ns / 1ps

// Bit-serial restoring remainder: one candidate bit per cycle, MSB first.
module tdp_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tdp_pkg::NW-1:0]    num,
  input  logic [tdp_pkg::DW-1:0]    div,
  output tdp_pkg::rem_stat_t        stat
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [tdp_pkg::CNTW-1:0]   cnt_r, cnt_nxt;
  logic [tdp_pkg::NW-1:0]     shreg_r, shreg_nxt;
  logic [tdp_pkg::DW-1:0]     rem_r, rem_nxt;
  logic [tdp_pkg::DW:0]       trial;

  // Partial remainder shifted left with the next candidate bit.
  assign trial = {rem_r, shreg_r[tdp_pkg::NW-1]};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    if (start && !busy_r) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = tdp_pkg::CNTW'(tdp_pkg::NW - 1);
      shreg_nxt = num;
      rem_nxt   = '0;
    end else if (busy_r) begin
      shreg_nxt = {shreg_r[tdp_pkg::NW-2:0], 1'b0};
      if (trial >= {1'b0, div}) begin
        rem_nxt = tdp_pkg::DW'(trial - {1'b0, div});
      end else begin
        rem_nxt = trial[tdp_pkg::DW-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    rem_r   <= rem_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

// ===== rtl/trial_division_prime_test.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Ports                          | Item
// --------+-----------+--------------------------------+--------------------------
// in      | input     | in_valid, in_ready, in_candidate | 32-bit unsigned candidate
// out     | output    | out_valid, out_ready, out_is_prime | 1-bit prime flag
//
// One item at a time. Candidates 0..3 and even numbers are settled in ST_CLASS.
// Odd candidates try divisors 3, 5, 7, ... while d*d <= n; each divisor runs
// through the bit-serial remainder unit, so a 32-bit prime tries about 32768
// divisors. The remainder unit sets the pace.
// Reset (rst_n low, synchronous) drops any item in flight and the output.
// A stalled result sits in the output register; the next item is accepted
// meanwhile and waits only when its own result is ready.
module trial_division_prime_test (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_candidate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_prime
);

  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for an item
  localparam logic [2:0] ST_CLASS = 3'd1;  // small / even shortcuts
  localparam logic [2:0] ST_TEST  = 3'd2;  // d*d <= n ? start remainder
  localparam logic [2:0] ST_WAIT  = 3'd3;  // remainder in progress
  localparam logic [2:0] ST_RES   = 3'd4;  // hand result to output reg

  logic [2:0]                state_r, state_nxt;
  logic [tdp_pkg::NW-1:0]    n_r, n_nxt;
  logic [tdp_pkg::DW-1:0]    d_r, d_nxt;
  logic [tdp_pkg::SW-1:0]    sq_r, sq_nxt;   // d_r squared
  logic                      res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_prime_r, out_prime_nxt;
  logic                      in_acc;
  logic                      rem_start;
  logic                      out_load;
  logic                      sq_le_n;
  tdp_pkg::rem_stat_t        rem_stat;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign sq_le_n   = (sq_r <= tdp_pkg::SW'(n_r));
  assign rem_start = (state_r == ST_TEST) && sq_le_n;
  // output register is free when empty or being drained this cycle
  assign out_load  = (state_r == ST_RES) && (!out_valid_r || out_ready);

  tdp_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .num   (n_r),
    .div   (d_r),
    .stat  (rem_stat)
  );

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    res_nxt   = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          n_nxt     = in_candidate[tdp_pkg::NW-1:0];
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (n_r < tdp_pkg::NW'(2)) begin
          res_nxt   = 1'b0;
          state_nxt = ST_RES;
        end else if (n_r < tdp_pkg::NW'(4)) begin
          res_nxt   = 1'b1;
          state_nxt = ST_RES;
        end else if (!n_r[0]) begin
          res_nxt   = 1'b0;
          state_nxt = ST_RES;
        end else begin
          d_nxt     = tdp_pkg::DW'(3);
          sq_nxt    = tdp_pkg::SW'(9);
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sq_le_n) begin
          state_nxt = ST_WAIT;
        end else begin
          // no divisor up to the square root
          res_nxt   = 1'b1;
          state_nxt = ST_RES;
        end
      end
      ST_WAIT: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            res_nxt   = 1'b0;
            state_nxt = ST_RES;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            d_nxt     = d_r + tdp_pkg::DW'(2);
            sq_nxt    = sq_r + tdp_pkg::SW'({d_r, 2'b00}) + tdp_pkg::SW'(4);
            state_nxt = ST_TEST;
          end
        end
      end
      ST_RES: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_prime_nxt = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

endmodule

// ===== rtl/tdp_checker.sv =====
`timescale 1ns / 1ps

module tdp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_candidate,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_prime
);

  // held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_prime))
    else $error("output item changed while stalled");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // zero, one and even numbers above two are reported not prime, fast
  a_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid &&
    ((in_candidate == 32'd0) || (in_candidate == 32'd1) ||
     (!in_candidate[0] && (in_candidate != 32'd2)))
    |-> ##3 (out_valid && !out_is_prime))
    else $error("trivial composite not flagged");

  // two and three are prime
  a_small_prime: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid &&
    ((in_candidate == 32'd2) || (in_candidate == 32'd3))
    |-> ##3 (out_valid && out_is_prime))
    else $error("two or three not flagged prime");

  // output register empty after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (.*);
